@@ rtl/bitmap_to_row_id_list_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap to row id list core
// Implication checks on the core clock, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BITMAP_TO_ROW_ID_LIST_CORE_ASSERT_SVH
`define BITMAP_TO_ROW_ID_LIST_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define BRL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in bitmap to row id list core");

`define BRL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in bitmap to row id list core");

`else

`define BRL_ASSERT_SAME(lbl, ante, cons)

`define BRL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/brl_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap to row id list package
// Widths, transaction types, controller state and shared helper functions.
// ----------------------------------------------------------------------------
package brl_pkg;

    localparam int ROW_ID_BITS  = 40;
    localparam int PAYLOAD_BITS = 31;
    localparam int VC_BITS      = 5;
    localparam int OFF_BITS     = 5;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] word_bits;
        logic [VC_BITS-1:0]      valid_count;
        logic                    end_of_bitmap;
    } t_in;

    typedef struct packed {
        logic [ROW_ID_BITS-1:0] row_id;
        logic                   last_of_word;
        logic                   bitmap_done;
    } t_out;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic in_empty;
        logic last;
    } t_dp_stat;

    function automatic logic [ROW_ID_BITS-1:0] sat_add(
        input logic [ROW_ID_BITS-1:0] base,
        input logic [OFF_BITS-1:0]    inc
    );
        logic [ROW_ID_BITS:0] sum;
        sum = {1'b0, base} + (ROW_ID_BITS+1)'(inc);
        if (sum[ROW_ID_BITS]) begin
            return {ROW_ID_BITS{1'b1}};
        end
        return sum[ROW_ID_BITS-1:0];
    endfunction

    function automatic logic [OFF_BITS-1:0] onehot_index(
        input logic [PAYLOAD_BITS-1:0] v
    );
        logic [OFF_BITS-1:0] idx;
        idx[0] = |(v & PAYLOAD_BITS'(32'haaaa_aaaa));
        idx[1] = |(v & PAYLOAD_BITS'(32'hcccc_cccc));
        idx[2] = |(v & PAYLOAD_BITS'(32'hf0f0_f0f0));
        idx[3] = |(v & PAYLOAD_BITS'(32'hff00_ff00));
        idx[4] = |(v & PAYLOAD_BITS'(32'hffff_0000));
        return idx;
    endfunction

endpackage

@@ rtl/brl_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bitmap to row id list controller
// Sequences word loads and per-id steps and owns the output valid flag.
// ----------------------------------------------------------------------------
module brl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output brl_pkg::t_dp_cmd  o_cmd,
    input  brl_pkg::t_dp_stat i_stat
);

    brl_pkg::t_state r_state;
    brl_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            brl_pkg::ST_IDLE: begin
                if (i_in_valid && !i_stat.in_empty) begin
                    n_state = brl_pkg::ST_EMIT;
                end
            end
            brl_pkg::ST_EMIT: begin
                if (out_free && i_stat.last) begin
                    n_state = brl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = brl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            brl_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            brl_pkg::ST_EMIT: begin
                o_cmd.step = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.step) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brl_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/brl_dp.sv @@
// ----------------------------------------------------------------------------
// Bitmap to row id list datapath
// Holds the row base and the pending bit mask and forms one row id per step.
// ----------------------------------------------------------------------------
module brl_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brl_pkg::t_in      i_in,
    input  brl_pkg::t_dp_cmd  i_cmd,
    output brl_pkg::t_dp_stat o_stat,
    output brl_pkg::t_out     o_out
);

    logic [brl_pkg::PAYLOAD_BITS-1:0] r_mask;
    logic [brl_pkg::PAYLOAD_BITS-1:0] n_mask;
    logic [brl_pkg::ROW_ID_BITS-1:0]  r_row_base;
    logic [brl_pkg::ROW_ID_BITS-1:0]  n_row_base;
    logic [brl_pkg::ROW_ID_BITS-1:0]  r_word_base;
    logic                             r_eob;
    brl_pkg::t_out                    r_out;
    brl_pkg::t_out                    n_out;

    logic [brl_pkg::PAYLOAD_BITS-1:0] rev_bits;
    logic [brl_pkg::PAYLOAD_BITS-1:0] load_mask;
    logic [brl_pkg::VC_BITS:0]        shift_amt;
    logic [brl_pkg::PAYLOAD_BITS-1:0] low_bit;
    logic [brl_pkg::PAYLOAD_BITS-1:0] rest_mask;
    logic [brl_pkg::OFF_BITS-1:0]     offset;

    // Reverse the word so the earliest row sits at bit zero.
    always_comb begin
        for (int k = 0; k < brl_pkg::PAYLOAD_BITS; k++) begin
            rev_bits[k] = i_in.word_bits[brl_pkg::PAYLOAD_BITS-1-k];
        end
    end

    assign shift_amt = (brl_pkg::VC_BITS+1)'(brl_pkg::PAYLOAD_BITS)
                     - {1'b0, i_in.valid_count};
    assign load_mask = rev_bits >> shift_amt;

    assign low_bit   = r_mask & (~r_mask + brl_pkg::PAYLOAD_BITS'(1));
    assign rest_mask = r_mask & ~low_bit;
    assign offset    = brl_pkg::onehot_index(low_bit);

    assign o_stat.in_empty = (load_mask == '0);
    assign o_stat.last     = (rest_mask == '0);

    always_comb begin
        n_mask     = r_mask;
        n_row_base = r_row_base;
        n_out      = r_out;
        if (i_cmd.load) begin
            n_mask = load_mask;
            if (i_in.end_of_bitmap) begin
                n_row_base = '0;
            end else begin
                n_row_base = brl_pkg::sat_add(r_row_base, i_in.valid_count);
            end
        end else if (i_cmd.step) begin
            n_mask             = rest_mask;
            n_out.row_id       = brl_pkg::sat_add(r_word_base, offset);
            n_out.last_of_word = (rest_mask == '0);
            n_out.bitmap_done  = (rest_mask == '0) && r_eob;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= '0;
            r_row_base <= '0;
        end else begin
            r_mask     <= n_mask;
            r_row_base <= n_row_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word_base <= r_row_base;
            r_eob       <= i_in.end_of_bitmap;
        end
        r_out <= n_out;
    end

    assign o_out = r_out;

endmodule

@@ rtl/bitmap_to_row_id_list_core.sv @@
// ----------------------------------------------------------------------------
// Bitmap to row id list core
// Turns uncompressed 31-bit bitmap payload words into ascending row ids.
// ----------------------------------------------------------------------------
// Input channel: i_in carries one payload word with its valid count and an
// end-of-bitmap flag; a transaction completes when i_in_valid is high and
// o_in_stall is low. Output channel: o_out carries one row id with the
// last-of-word and bitmap-done marks; it completes when o_out_valid is high
// and i_out_stall is low. Each set valid bit yields one row id, base plus
// the bit's offset, and the row base then advances by the valid count,
// saturating at its maximum, or returns to zero after an end-of-bitmap word.
// A word with set bits holds the input channel until its last id is
// stepped, also while the receiver stalls; a word with no set bit is taken
// without holding the channel. Within a word one id leaves per cycle while
// the output is not stalled, set by the single id step of the datapath. A
// stalled output holds its id and pauses the emission. Synchronous reset
// returns the row base to zero and empties the output register; the block
// accepts input in the first cycle after it.
// ----------------------------------------------------------------------------
module bitmap_to_row_id_list_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  brl_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output brl_pkg::t_out o_out
);

    brl_pkg::t_dp_cmd  dp_cmd;
    brl_pkg::t_dp_stat dp_stat;

    brl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    brl_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_out   (o_out)
    );

`include "bitmap_to_row_id_list_core_assert.svh"

    `BRL_ASSERT_SAME(a_done_is_last, o_out_valid && o_out.bitmap_done, o_out.last_of_word)
    `BRL_ASSERT_SAME(a_more_ids_busy, o_out_valid && !o_out.last_of_word, o_in_stall)
    `BRL_ASSERT_SAME(a_idle_after_last, $fell(o_in_stall), o_out_valid && o_out.last_of_word)
    `BRL_ASSERT_SAME(a_step_no_load, dp_cmd.step, !dp_cmd.load)

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Bitmap to row id list core testbench
// Drives payload words through the input channel and checks every row id
// against a cycle-free prediction. The prediction keeps its own row base,
// walks the valid bits from the earliest row down, and queues the ids with
// their last-of-word and bitmap-done marks. A directed set of words comes
// first, then random bitmaps mixed with stray words, with random idling on
// both channels and a full drain between phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT      = 24;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_LIMIT   = 40;
    localparam logic [brl_pkg::ROW_ID_BITS-1:0] ROW_ID_MAX = {brl_pkg::ROW_ID_BITS{1'b1}};

    logic          clk      = 1'b0;
    logic          rst_n    = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    brl_pkg::t_in  in_word  = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    brl_pkg::t_out out_id;
    logic          calm;

    brl_pkg::t_in  pending_words[$];
    brl_pkg::t_out expected_ids[$];
    logic [brl_pkg::ROW_ID_BITS-1:0] next_row_base = '0;

    int unsigned cycle_cnt      = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned mismatch_cnt   = 0;
    int unsigned words_queued   = 0;
    int unsigned words_taken    = 0;
    int unsigned ids_seen       = 0;
    int unsigned bitmaps_closed = 0;

    bitmap_to_row_id_list_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_id)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One stretch in four, picked by bits 10:9 of the cycle counter, runs with no idling on either side.
    assign calm = (cycle_cnt[10:9] == 2'b01);

    function automatic logic [brl_pkg::ROW_ID_BITS-1:0] add_clamped(
        input logic [brl_pkg::ROW_ID_BITS-1:0] base,
        input int unsigned                     inc
    );
        logic [brl_pkg::ROW_ID_BITS:0] sum;
        sum = {1'b0, base} + (brl_pkg::ROW_ID_BITS+1)'(inc);
        return sum[brl_pkg::ROW_ID_BITS] ? ROW_ID_MAX : sum[brl_pkg::ROW_ID_BITS-1:0];
    endfunction

    function automatic void predict_row_ids(input brl_pkg::t_in w);
        logic [brl_pkg::PAYLOAD_BITS-1:0] live;
        brl_pkg::t_out id;
        int   vc;
        vc   = int'(w.valid_count);
        live = w.word_bits & ((brl_pkg::PAYLOAD_BITS'(1) << vc)
                              - brl_pkg::PAYLOAD_BITS'(1));
        for (int b = brl_pkg::PAYLOAD_BITS - 1; b >= 0; b--) begin
            if (live[b]) begin
                live[b]         = 1'b0;
                id.row_id       = add_clamped(next_row_base, vc - 1 - b);
                id.last_of_word = (live == '0);
                id.bitmap_done  = (live == '0) && w.end_of_bitmap;
                expected_ids.insert(expected_ids.size(), id);
            end
        end
        next_row_base = w.end_of_bitmap ? '0 : add_clamped(next_row_base, vc);
    endfunction

    task automatic report_mismatch(
        input string                           what,
        input logic [brl_pkg::ROW_ID_BITS-1:0] got,
        input logic [brl_pkg::ROW_ID_BITS-1:0] want
    );
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_LIMIT) begin
            $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
        end
    endtask

    function automatic void queue_word(input logic [brl_pkg::PAYLOAD_BITS-1:0] bits,
                                       input int vc, input logic eob);
        brl_pkg::t_in w;
        w.word_bits     = bits;
        w.valid_count   = brl_pkg::VC_BITS'(vc);
        w.end_of_bitmap = eob;
        pending_words.insert(pending_words.size(), w);
        words_queued++;
    endfunction

    function automatic logic [brl_pkg::PAYLOAD_BITS-1:0] random_bits();
        case ($urandom_range(3))
            0: return brl_pkg::PAYLOAD_BITS'($urandom & $urandom & $urandom);
            1: return brl_pkg::PAYLOAD_BITS'($urandom);
            2: return brl_pkg::PAYLOAD_BITS'($urandom | $urandom);
            default: return brl_pkg::PAYLOAD_BITS'(1)
                            << $urandom_range(brl_pkg::PAYLOAD_BITS - 1);
        endcase
    endfunction

    task automatic queue_random(input int unsigned count);
        int unsigned made;
        int unsigned words;
        made = 0;
        while (made < count) begin
            if ($urandom_range(9) < 2) begin
                queue_word(random_bits(), int'($urandom_range(31)), 1'($urandom_range(1)));
                made++;
            end else begin
                words = $urandom_range(1, 5);
                repeat (words - 1) queue_word(random_bits(), brl_pkg::PAYLOAD_BITS, 1'b0);
                queue_word(random_bits(), int'($urandom_range(1, brl_pkg::PAYLOAD_BITS)),
                           1'b1);
                made += words;
            end
        end
    endtask

    task automatic wait_for_drain();
        while (words_taken != words_queued || expected_ids.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                predict_row_ids(in_word);
                words_taken++;
            end
            if (pending_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                in_valid <= 1'b1;
                in_word  <= pending_words.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        brl_pkg::t_out want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                ids_seen++;
                if (expected_ids.size() == 0) begin
                    report_mismatch("row id with none pending", out_id.row_id, '0);
                end else begin
                    want = expected_ids.pop_front();
                    if (out_id.row_id !== want.row_id) begin
                        report_mismatch("row_id", out_id.row_id, want.row_id);
                    end
                    if (out_id.last_of_word !== want.last_of_word) begin
                        report_mismatch("last_of_word",
                                        brl_pkg::ROW_ID_BITS'(out_id.last_of_word),
                                        brl_pkg::ROW_ID_BITS'(want.last_of_word));
                    end
                    if (out_id.bitmap_done !== want.bitmap_done) begin
                        report_mismatch("bitmap_done",
                                        brl_pkg::ROW_ID_BITS'(out_id.bitmap_done),
                                        brl_pkg::ROW_ID_BITS'(want.bitmap_done));
                    end
                    if (want.bitmap_done) begin
                        bitmaps_closed++;
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timed out after %0d cycles without a transaction.", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        queue_word('0, brl_pkg::PAYLOAD_BITS, 1'b0);
        queue_word({brl_pkg::PAYLOAD_BITS{1'b1}}, brl_pkg::PAYLOAD_BITS, 1'b0);
        queue_word(brl_pkg::PAYLOAD_BITS'(32'haaaa_aaaa), brl_pkg::PAYLOAD_BITS, 1'b0);
        queue_word(brl_pkg::PAYLOAD_BITS'(32'h5555_5555), brl_pkg::PAYLOAD_BITS, 1'b0);
        queue_word(brl_pkg::PAYLOAD_BITS'(32'hf0f0_f0f0), brl_pkg::PAYLOAD_BITS, 1'b0);
        queue_word(brl_pkg::PAYLOAD_BITS'(32'hff00_ff00), brl_pkg::PAYLOAD_BITS, 1'b0);
        queue_word(brl_pkg::PAYLOAD_BITS'(1) << (brl_pkg::PAYLOAD_BITS - 1),
                   brl_pkg::PAYLOAD_BITS, 1'b0);
        queue_word(brl_pkg::PAYLOAD_BITS'(1), brl_pkg::PAYLOAD_BITS, 1'b1);
        queue_word(brl_pkg::PAYLOAD_BITS'(1), 1, 1'b0);
        queue_word(brl_pkg::PAYLOAD_BITS'(32'h7fff_ffe0) | brl_pkg::PAYLOAD_BITS'(5'h15),
                   5, 1'b0);
        queue_word({brl_pkg::PAYLOAD_BITS{1'b1}}, 0, 1'b0);
        queue_word(brl_pkg::PAYLOAD_BITS'(32'h0001_0001), brl_pkg::PAYLOAD_BITS, 1'b0);
        queue_word({brl_pkg::PAYLOAD_BITS{1'b1}}, 0, 1'b1);
        queue_word(brl_pkg::PAYLOAD_BITS'(32'h0000_0003), 17, 1'b0);
        queue_word('0, brl_pkg::PAYLOAD_BITS, 1'b1);
        queue_word(brl_pkg::PAYLOAD_BITS'(32'h0000_8421), 16, 1'b0);
        queue_word({brl_pkg::PAYLOAD_BITS{1'b1}}, brl_pkg::PAYLOAD_BITS, 1'b1);
        queue_word(brl_pkg::PAYLOAD_BITS'(32'h4000_0001), brl_pkg::PAYLOAD_BITS, 1'b0);
        queue_word({brl_pkg::PAYLOAD_BITS{1'b1}}, 30, 1'b1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait_for_drain();
        queue_random(55);
        wait_for_drain();
        queue_random(55);
        wait_for_drain();

        $display("Ran %0d payload words, %0d row ids and %0d finished bitmaps in %0d cycles.",
                 words_taken, ids_seen, bitmaps_closed, cycle_cnt);
        $display("Total mismatches: %0d.", mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/brl_pkg.sv
rtl/brl_ctrl.sv
rtl/brl_dp.sv
rtl/bitmap_to_row_id_list_core.sv
bench/tb.sv
